>>> rtl/lkt_pkg.sv
// Package for the link key table: request/response word types, entry type,
// command codes and size constants. No dependencies.

package lkt_pkg;

   // Default table depth and the width of the reported entry count
   localparam int LKT_DEPTH   = 32;
   localparam int LKT_COUNT_W = 6;

   // Command codes
   localparam logic [2:0] CMD_GET        = 3'd0;
   localparam logic [2:0] CMD_PUT        = 3'd1;
   localparam logic [2:0] CMD_DELETE     = 3'd2;
   localparam logic [2:0] CMD_ITER_RESET = 3'd3;
   localparam logic [2:0] CMD_ITER_NEXT  = 3'd4;

   typedef logic [LKT_COUNT_W-1:0] lkt_count_type;

   // One request word
   typedef struct packed {
      logic [2:0]  command;
      logic [47:0] address;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [7:0]  key_type;
   } lkt_req_type;

   // One response word
   typedef struct packed {
      logic          found;
      logic          evicted;
      logic [47:0]   entry_address;
      logic [63:0]   entry_key_high;
      logic [63:0]   entry_key_low;
      logic [7:0]    entry_type;
      lkt_count_type entry_count;
   } lkt_rsp_type;

   // One table entry as stored in memory
   typedef struct packed {
      logic [47:0] address;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [7:0]  key_type;
   } lkt_entry_type;

endpackage

>>> rtl/link_key_table_fifo_evict.sv
// Link key table with oldest-first eviction, one command at a time: a new
// command is accepted only once the response to the last one has been loaded
// into the output register. Get, put and delete scan the table linearly; a
// delete hit shifts the later entries down, and a put miss on a full table
// shifts all entries down, dropping the oldest, before writing at the end.
// Synchronous reset empties the table and zeroes the iterator; no memory sweep.

module link_key_table_fifo_evict
   import lkt_pkg::*;
#(
   parameter int DEPTH = LKT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lkt_req_type  req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lkt_rsp_type  rsp_data
);

   localparam int IW = $clog2(DEPTH);

   logic [IW-1:0] rd_idx;
   logic [IW-1:0] wr_idx;
   lkt_entry_type rd_data;
   lkt_entry_type wr_data;
   logic          wr_en;
   logic          out_free;
   logic          rsp_load;
   lkt_rsp_type   rsp_word;
   logic          rsp_valid_ff;
   lkt_rsp_type   rsp_ff;

   lkt_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   lkt_seq #(.DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_word  (rsp_word)
   );

   // Output register; free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/lkt_mem.sv
// Entry storage for the link key table: one write port, one read port,
// registered read data. Depends on lkt_pkg.

module lkt_mem
   import lkt_pkg::*;
#(
   parameter int DEPTH = LKT_DEPTH
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_idx,
   input  lkt_entry_type              wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_idx,
   output lkt_entry_type              rd_data
);

   lkt_entry_type mem [DEPTH];
   lkt_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lkt_seq.sv
// Command sequencer for the link key table: linear address scan, shift
// engine for eviction and delete, iterator, and response assembly.
// Depends on lkt_pkg; drives the ports of lkt_mem.

module lkt_seq
   import lkt_pkg::*;
#(
   parameter int DEPTH = LKT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  lkt_req_type                req_data,
   output logic                       req_stall,
   output logic [$clog2(DEPTH)-1:0]   rd_idx,
   input  lkt_entry_type              rd_data,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_idx,
   output lkt_entry_type              wr_data,
   input  logic                       out_free,
   output logic                       rsp_load,
   output lkt_rsp_type                rsp_word
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL     = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_WRITE,
      S_ITER_RD,
      S_ITER_CAP,
      S_RESP
   } state_type;

   state_type     state_ff;
   lkt_req_type   req_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] iter_ff;
   logic [CW-1:0] idx_ff;      // scan read index, also shift source index
   logic [CW-1:0] end_ff;      // shift source limit (exclusive)
   logic          cmp_v_ff;
   logic [IW-1:0] cmp_idx_ff;
   logic [IW-1:0] pos_ff;      // entry to write on put
   logic          mv_v_ff;
   logic [IW-1:0] mv_dst_ff;
   logic          found_ff;
   logic          evict_ff;
   logic [47:0]   o_addr_ff;
   logic [63:0]   o_khi_ff;
   logic [63:0]   o_klo_ff;
   logic [7:0]    o_type_ff;

   logic scan_issue;
   logic scan_hit;
   logic shift_issue;

   assign req_stall   = (state_ff != S_IDLE);
   assign scan_issue  = (idx_ff < count_ff);
   assign scan_hit    = cmp_v_ff && (rd_data.address == req_ff.address);
   assign shift_issue = (idx_ff < end_ff);

   // Memory read address
   always_comb begin
      case (state_ff)
         S_ITER_RD: rd_idx = iter_ff[IW-1:0];
         default:   rd_idx = idx_ff[IW-1:0];
      endcase
   end

   // Memory write: shifted entry or new/updated entry
   always_comb begin
      wr_en   = (state_ff == S_WRITE) || ((state_ff == S_SHIFT) && mv_v_ff);
      wr_idx  = (state_ff == S_WRITE) ? pos_ff : mv_dst_ff;
      wr_data = rd_data;
      if (state_ff == S_WRITE) begin
         wr_data.address  = req_ff.address;
         wr_data.key_high = req_ff.key_high;
         wr_data.key_low  = req_ff.key_low;
         wr_data.key_type = req_ff.key_type;
      end
   end

   // Response word
   assign rsp_load = (state_ff == S_RESP) && out_free;
   always_comb begin
      rsp_word.found          = found_ff;
      rsp_word.evicted        = evict_ff;
      rsp_word.entry_address  = o_addr_ff;
      rsp_word.entry_key_high = o_khi_ff;
      rsp_word.entry_key_low  = o_klo_ff;
      rsp_word.entry_type     = o_type_ff;
      rsp_word.entry_count    = lkt_count_type'(count_ff);
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         iter_ff  <= '0;
         cmp_v_ff <= 1'b0;
         mv_v_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  found_ff  <= 1'b0;
                  evict_ff  <= 1'b0;
                  o_addr_ff <= req_data.address;
                  // put answers with the key it stores, everything else starts from zero
                  if (req_data.command == CMD_PUT) begin
                     o_khi_ff  <= req_data.key_high;
                     o_klo_ff  <= req_data.key_low;
                     o_type_ff <= req_data.key_type;
                  end else begin
                     o_khi_ff  <= '0;
                     o_klo_ff  <= '0;
                     o_type_ff <= '0;
                  end
                  idx_ff    <= '0;
                  cmp_v_ff  <= 1'b0;
                  case (req_data.command)
                     CMD_GET, CMD_PUT, CMD_DELETE: begin
                        state_ff <= S_SCAN;
                     end
                     CMD_ITER_RESET: begin
                        iter_ff  <= '0;
                        state_ff <= S_RESP;
                     end
                     CMD_ITER_NEXT: begin
                        state_ff <= (iter_ff < count_ff) ? S_ITER_RD : S_RESP;
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end

            // One read issued per cycle; compare data of the previous read
            S_SCAN: begin
               cmp_v_ff   <= scan_issue;
               cmp_idx_ff <= idx_ff[IW-1:0];
               if (scan_hit) begin
                  found_ff <= 1'b1;
                  pos_ff   <= cmp_idx_ff;
                  case (req_ff.command)
                     CMD_PUT: begin
                        state_ff <= S_WRITE;
                     end
                     CMD_DELETE: begin
                        o_khi_ff  <= rd_data.key_high;
                        o_klo_ff  <= rd_data.key_low;
                        o_type_ff <= rd_data.key_type;
                        idx_ff    <= CW'(cmp_idx_ff) + 1'b1;
                        end_ff    <= count_ff;
                        mv_v_ff   <= 1'b0;
                        state_ff  <= S_SHIFT;
                     end
                     default: begin
                        o_khi_ff  <= rd_data.key_high;
                        o_klo_ff  <= rd_data.key_low;
                        o_type_ff <= rd_data.key_type;
                        state_ff  <= S_RESP;
                     end
                  endcase
               end else if (!cmp_v_ff && !scan_issue) begin
                  // miss
                  if (req_ff.command == CMD_PUT) begin
                     if (count_ff == FULL) begin
                        evict_ff <= 1'b1;
                        idx_ff   <= CW'(1);
                        end_ff   <= FULL;
                        mv_v_ff  <= 1'b0;
                        pos_ff   <= LAST_IDX;
                        state_ff <= S_SHIFT;
                     end else begin
                        pos_ff   <= count_ff[IW-1:0];
                        count_ff <= count_ff + 1'b1;
                        state_ff <= S_WRITE;
                     end
                  end else begin
                     state_ff <= S_RESP;
                  end
               end else if (scan_issue) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            // Move entry src to src-1, pipelined through the read latency
            S_SHIFT: begin
               mv_v_ff   <= shift_issue;
               mv_dst_ff <= IW'(idx_ff - 1'b1);
               if (shift_issue) begin
                  idx_ff <= idx_ff + 1'b1;
               end else if (!mv_v_ff) begin
                  if (req_ff.command == CMD_PUT) begin
                     state_ff <= S_WRITE;
                  end else begin
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_RESP;
                  end
               end
            end

            S_WRITE: begin
               state_ff <= S_RESP;
            end

            S_ITER_RD: begin
               iter_ff  <= iter_ff + 1'b1;
               state_ff <= S_ITER_CAP;
            end

            S_ITER_CAP: begin
               found_ff  <= 1'b1;
               o_addr_ff <= rd_data.address;
               o_khi_ff  <= rd_data.key_high;
               o_klo_ff  <= rd_data.key_low;
               o_type_ff <= rd_data.key_type;
               state_ff  <= S_RESP;
            end

            S_RESP: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/lkt_chk.sv
// Port-level checks for the link key table, bound to the top level.
// Depends on lkt_pkg.

module lkt_chk
   import lkt_pkg::*;
#(
   parameter int DEPTH = LKT_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input lkt_rsp_type rsp_data
);

   localparam lkt_count_type FULL_COUNT = lkt_count_type'(DEPTH);

   // A stalled response word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word dropped or changed while stalled");

   // One command in flight: the word after an accept is stalled
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while a command is in progress");

   // Eviction only on a put miss into a full table
   a_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |->
         !rsp_data.found && rsp_data.entry_count == FULL_COUNT)
      else $error("eviction reported without a full table");

   // Count never exceeds the depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (DEPTH < 64) |-> rsp_data.entry_count <= FULL_COUNT)
      else $error("entry count above table depth");

endmodule

bind link_key_table_fifo_evict lkt_chk #(.DEPTH(DEPTH)) u_lkt_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
